/* rtl/rtc_pkg.sv */
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared constants, types and helper functions of the RGB theme colour
// transform.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam logic [23:0] SELECT_COLOUR_A   = 24'd32225;
    localparam logic [23:0] SELECT_COLOUR_B   = 24'd21985;
    localparam logic [8:0]  SELECT_B_SCALE_Q8 = 9'd192;
    localparam int          HUE_SLOTS         = 4;
    localparam logic [7:0]  MIN_HUE_CHROMA    = 8'd24;

    localparam logic [13:0] HUE_SCALE   = 14'd43;
    localparam logic [7:0]  HUE_BASE_G  = 8'd85;
    localparam logic [7:0]  HUE_BASE_B  = 8'd171;

    localparam int HUE_Q_W = 6;
    localparam int MAP_Q_W = 9;

    localparam logic [2:0] REG_SELECTION   = 3'd0;
    localparam logic [2:0] REG_CONTROL     = 3'd1;
    localparam logic [2:0] REG_SAT_DARKEN  = 3'd2;
    localparam logic [2:0] REG_CHROMA      = 3'd3;
    localparam logic [2:0] REG_HUE_PULL    = 3'd4;
    localparam logic [2:0] REG_TARGETS_LO  = 3'd5;
    localparam logic [2:0] REG_TARGETS_HI  = 3'd6;
    localparam logic [2:0] REG_DUOTONE     = 3'd7;

    typedef struct packed {
        logic [13:0] mag;
        logic        neg;
        logic [7:0]  base;
        logic [7:0]  chroma;
        logic [7:0]  mid;
    } hue_setup_t;

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

    function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [11:0] v);
        logic [7:0] res;
        if (v < 0)
        begin
            res = 8'd0;
        end
        else if (v > 12'sd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

    function automatic hue_setup_t hue_setup(input logic [23:0] rgb);
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
        logic [7:0]        mx;
        logic [7:0]        mn;
        logic signed [8:0] diff;
        logic [7:0]        mag8;
        hue_setup_t        hs;
        r  = rgb[23:16];
        g  = rgb[15:8];
        b  = rgb[7:0];
        mx = max3(r, g, b);
        mn = min3(r, g, b);
        if (mx == r)
        begin
            diff    = $signed({1'b0, g}) - $signed({1'b0, b});
            hs.base = 8'd0;
        end
        else if (mx == g)
        begin
            diff    = $signed({1'b0, b}) - $signed({1'b0, r});
            hs.base = HUE_BASE_G;
        end
        else
        begin
            diff    = $signed({1'b0, r}) - $signed({1'b0, g});
            hs.base = HUE_BASE_B;
        end
        hs.neg    = diff[8];
        mag8      = diff[8] ? 8'(-diff) : diff[7:0];
        hs.mag    = {6'd0, mag8} * HUE_SCALE;
        hs.chroma = mx - mn;
        hs.mid    = 8'(({1'b0, mx} + {1'b0, mn}) >> 1);
        return hs;
    endfunction

    function automatic logic [7:0] hue_finish(input logic [7:0] base, input logic neg,
                                              input logic [HUE_Q_W-1:0] q);
        logic [7:0] qe;
        qe = 8'(q);
        return neg ? (base - qe) : (base + qe);
    endfunction

    function automatic logic [7:0] hue_dist(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return (d > 8'd128) ? 8'(9'd256 - {1'b0, d}) : d;
    endfunction

    // floor(y / 255) for y up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] y);
        logic [16:0] s;
        s = {1'b0, y} + 17'd1 + {9'd0, y[15:8]};
        return s[15:8];
    endfunction

    // x / 256 truncated toward zero
    function automatic logic signed [10:0] trunc_q8(input logic signed [18:0] x);
        logic [18:0]        m;
        logic signed [10:0] q;
        m = x[18] ? 19'(-x) : 19'(x);
        q = $signed(11'(m >> 8));
        return x[18] ? -q : q;
    endfunction

endpackage

/* rtl/rtc_div.sv */
// ----------------------------------------------------------------------------
// rtc_div
// Pipelined restoring divider, one quotient bit per stage. The numerator
// must stay below den << Q_W.
// ----------------------------------------------------------------------------
module rtc_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 8,
    parameter int Q_W   = 6
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    localparam int RW = DEN_W + Q_W;

    logic [RW-1:0]    rem_in   [Q_W];
    logic [DEN_W-1:0] den_in   [Q_W];
    logic [Q_W-1:0]   quo_in   [Q_W];
    logic [RW-1:0]    sub      [Q_W];
    logic [RW-1:0]    rem_next [Q_W];
    logic [Q_W-1:0]   quo_next [Q_W];
    logic [RW-1:0]    rem_reg  [Q_W];
    logic [DEN_W-1:0] den_reg  [Q_W];
    logic [Q_W-1:0]   quo_reg  [Q_W];

    always_comb
    begin
        for (int k = 0; k < Q_W; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = RW'(num);
                den_in[k] = den;
                quo_in[k] = '0;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1];
                den_in[k] = den_reg[k-1];
                quo_in[k] = quo_reg[k-1];
            end
            sub[k] = RW'(den_in[k]) << (Q_W - 1 - k);
            if (rem_in[k] >= sub[k])
            begin
                rem_next[k] = rem_in[k] - sub[k];
                quo_next[k] = quo_in[k] | (Q_W'(1) << (Q_W - 1 - k));
            end
            else
            begin
                rem_next[k] = rem_in[k];
                quo_next[k] = quo_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

/* rtl/rgb_theme_colour_transform.sv */
// ----------------------------------------------------------------------------
// rgb_theme_colour_transform
// Recolours a stream of RGB pixels: selection substitution, lightness
// inversion, saturation darkening, chroma scaling, hue mapping and duotone.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one pixel per clock while the output
// is not stalled. The pipeline holds two kinds of restoring dividers:
// six stages for hue angles, nine stages for the hue-mapped channels. A stall
// on the output holds the whole pipeline. Configuration writes are accepted
// at any time and take effect for pixels sent after the pipeline has drained.
module rgb_theme_colour_transform
    import rtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_rgb[23:0]
    input  logic        s_tuser,   // is_fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_rgb[23:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [56:0] cfg_data
);

    typedef struct packed {
        logic [2:0][7:0] ch;
        logic [15:0]     f;
        logic            dark_on;
        logic            sel_hit;
        logic [23:0]     sel_rgb;
    } p1_t;

    typedef struct packed {
        logic [2:0][23:0] prod;
        logic [2:0][7:0]  ch;
        logic             dark_on;
        logic             sel_hit;
        logic [23:0]      sel_rgb;
    } p2_t;

    typedef struct packed {
        logic [2:0][7:0] ch;
        logic            sel_hit;
        logic [23:0]     sel_rgb;
    } p3_t;

    typedef struct packed {
        logic [2:0][19:0] prod;
        logic [7:0]       mid;
        logic [2:0][7:0]  ch;
        logic             scale_on;
        logic             sel_hit;
        logic [23:0]      sel_rgb;
    } p4_t;

    typedef struct packed {
        logic [2:0][7:0] ch;
        logic [7:0]      nc;
        logic [7:0]      smid;
        logic            neg;
        logic [7:0]      base;
        logic            sel_hit;
        logic [23:0]     sel_rgb;
    } carry_t;

    typedef struct packed {
        logic [2:0][7:0]  ch;
        logic [7:0]       nc;
        logic [7:0]       smid;
        logic [1:0]       best;
        logic             map_on;
        logic [2:0][15:0] dp;
        logic [2:0]       dneg;
        logic             sel_hit;
        logic [23:0]      sel_rgb;
    } g_t;

    typedef struct packed {
        logic [2:0][7:0] ch;
        logic [7:0]      nc;
        logic [7:0]      smid;
        logic [2:0][7:0] tch;
        logic [7:0]      tc;
        logic [7:0]      tmid;
        logic [18:0]     mp;
        logic [18:0]     sp;
        logic [2:0][7:0] ramp;
        logic            map_on;
        logic            sel_hit;
        logic [23:0]     sel_rgb;
    } h_t;

    typedef struct packed {
        logic [7:0]      mid;
        logic [7:0]      spread;
        logic [7:0]      tc;
        logic [2:0][8:0] diff;
        logic            map_on;
        logic [2:0][7:0] duo;
        logic            sel_hit;
        logic [23:0]     sel_rgb;
    } i_t;

    typedef struct packed {
        logic [7:0]      mid;
        logic [2:0]      neg;
        logic            map_on;
        logic [2:0][7:0] duo;
        logic            sel_hit;
        logic [23:0]     sel_rgb;
    } m_t;

    logic [23:0] selection_colour_reg;
    logic [4:0]  control_flags_reg;
    logic [8:0]  sat_darken_reg;
    logic [9:0]  chroma_scale_reg;
    logic [8:0]  hue_pull_reg;
    logic [47:0] targets_lo_reg;
    logic [47:0] targets_hi_reg;
    logic [56:0] duotone_reg;

    logic en;
    logic [2:0] nhue;
    logic [3:0][23:0] tgt;
    hue_setup_t ts [4];
    logic [HUE_Q_W-1:0] tgt_q [4];
    logic [3:0][7:0] tgt_hue;
    logic [3:0][7:0] tgt_dist;
    logic [8:0] tint;

    logic [4:0] pv_reg;
    logic [HUE_Q_W-1:0] hv_reg;
    logic [2:0] tv_reg;
    logic [MAP_Q_W-1:0] mv_reg;
    logic out_valid_reg;
    logic [23:0] out_reg;
    logic [23:0] out_next;

    p1_t p1_reg, p1_next;
    p2_t p2_reg, p2_next;
    p3_t p3_reg, p3_next;
    p4_t p4_reg, p4_next;
    p3_t p5_reg, p5_next;
    carry_t hq_next;
    carry_t hq_reg [HUE_Q_W];
    g_t g_reg, g_next;
    h_t h_reg, h_next;
    i_t i_reg, i_next;
    m_t mq_next;
    m_t mq_reg [MAP_Q_W];

    hue_setup_t pix_hs;
    logic [HUE_Q_W-1:0] pix_q;
    logic [2:0][15:0] map_num;
    logic [2:0][MAP_Q_W-1:0] map_q;

    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign nhue      = control_flags_reg[4:2];
    assign tgt[0]    = targets_lo_reg[23:0];
    assign tgt[1]    = targets_lo_reg[47:24];
    assign tgt[2]    = targets_hi_reg[23:0];
    assign tgt[3]    = targets_hi_reg[47:24];
    assign tint      = (duotone_reg[56:48] > 9'd256) ? 9'd256 : duotone_reg[56:48];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            selection_colour_reg <= '0;
            control_flags_reg    <= '0;
            sat_darken_reg       <= '0;
            chroma_scale_reg     <= '0;
            hue_pull_reg         <= '0;
            targets_lo_reg       <= '0;
            targets_hi_reg       <= '0;
            duotone_reg          <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SELECTION:  selection_colour_reg <= cfg_data[23:0];
                REG_CONTROL:    control_flags_reg    <= cfg_data[4:0];
                REG_SAT_DARKEN: sat_darken_reg       <= cfg_data[8:0];
                REG_CHROMA:     chroma_scale_reg     <= cfg_data[9:0];
                REG_HUE_PULL:   hue_pull_reg         <= cfg_data[8:0];
                REG_TARGETS_LO: targets_lo_reg       <= cfg_data[47:0];
                REG_TARGETS_HI: targets_hi_reg       <= cfg_data[47:0];
                REG_DUOTONE:    duotone_reg          <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Stage 1: selection match, inversion, darkening factor
    always_comb
    begin
        logic [7:0]  mx;
        logic [7:0]  mn;
        logic [7:0]  c;
        logic [8:0]  q;
        logic [16:0] sp;
        logic [16:0] sd_c;
        logic        exempt;
        logic [2:0][7:0] src;
        src = s_tdata;
        mx  = max3(src[2], src[1], src[0]);
        mn  = min3(src[2], src[1], src[0]);
        c   = mx - mn;
        q   = (s_tdata == SELECT_COLOUR_A) ? 9'd256 : SELECT_B_SCALE_Q8;
        p1_next.sel_hit = s_tuser && (selection_colour_reg != 24'd0) &&
                          ((s_tdata == SELECT_COLOUR_A) || (s_tdata == SELECT_COLOUR_B));
        p1_next.sel_rgb = '0;
        for (int j = 0; j < 3; j++)
        begin
            sp = {9'd0, selection_colour_reg[8*j +: 8]} * {8'd0, q};
            p1_next.sel_rgb[8*j +: 8] = (sp[16:8] > 9'd255) ? 8'd255 : sp[15:8];
            if (control_flags_reg[0])
            begin
                p1_next.ch[j] = 8'(10'd255 - 10'(mx) - 10'(mn) + 10'(src[j]));
            end
            else
            begin
                p1_next.ch[j] = src[j];
            end
        end
        exempt = s_tuser && control_flags_reg[1] && (src[0] > src[2]) && (src[0] > src[1]);
        sd_c   = {8'd0, sat_darken_reg} * {9'd0, c};
        p1_next.f = (sd_c >= 17'd65280) ? 16'd0 : 16'(17'd65280 - sd_c);
        p1_next.dark_on = (sat_darken_reg != 9'd0) && (c != 8'd0) && !exempt;
    end

    // Stage 2: darkening products
    always_comb
    begin
        p2_next.ch      = p1_reg.ch;
        p2_next.dark_on = p1_reg.dark_on;
        p2_next.sel_hit = p1_reg.sel_hit;
        p2_next.sel_rgb = p1_reg.sel_rgb;
        for (int j = 0; j < 3; j++)
        begin
            p2_next.prod[j] = {16'd0, p1_reg.ch[j]} * {8'd0, p1_reg.f};
        end
    end

    // Stage 3: divide by 65280
    always_comb
    begin
        p3_next.sel_hit = p2_reg.sel_hit;
        p3_next.sel_rgb = p2_reg.sel_rgb;
        for (int j = 0; j < 3; j++)
        begin
            p3_next.ch[j] = p2_reg.dark_on ? div255(p2_reg.prod[j][23:8]) : p2_reg.ch[j];
        end
    end

    // Stage 4: chroma scale products about mid-lightness
    always_comb
    begin
        logic [7:0]         mx;
        logic [7:0]         mn;
        logic signed [8:0]  diff;
        logic signed [19:0] prod;
        mx = max3(p3_reg.ch[2], p3_reg.ch[1], p3_reg.ch[0]);
        mn = min3(p3_reg.ch[2], p3_reg.ch[1], p3_reg.ch[0]);
        p4_next.mid      = 8'(({1'b0, mx} + {1'b0, mn}) >> 1);
        p4_next.ch       = p3_reg.ch;
        p4_next.scale_on = (chroma_scale_reg != 10'd0) && (chroma_scale_reg != 10'd256);
        p4_next.sel_hit  = p3_reg.sel_hit;
        p4_next.sel_rgb  = p3_reg.sel_rgb;
        for (int j = 0; j < 3; j++)
        begin
            diff = $signed({1'b0, p3_reg.ch[j]}) - $signed({1'b0, p4_next.mid});
            prod = diff * $signed({1'b0, chroma_scale_reg});
            p4_next.prod[j] = prod;
        end
    end

    // Stage 5: shift and clamp
    always_comb
    begin
        logic signed [11:0] v;
        p5_next.sel_hit = p4_reg.sel_hit;
        p5_next.sel_rgb = p4_reg.sel_rgb;
        for (int j = 0; j < 3; j++)
        begin
            v = 12'($signed({4'b0, p4_reg.mid}) + ($signed(p4_reg.prod[j]) >>> 8));
            p5_next.ch[j] = p4_reg.scale_on ? clamp8(v) : p4_reg.ch[j];
        end
    end

    // Stage 6: hue setup for the pixel and the targets, feed dividers
    always_comb
    begin
        pix_hs          = hue_setup(p5_reg.ch);
        hq_next.ch      = p5_reg.ch;
        hq_next.nc      = pix_hs.chroma;
        hq_next.smid    = pix_hs.mid;
        hq_next.neg     = pix_hs.neg;
        hq_next.base    = pix_hs.base;
        hq_next.sel_hit = p5_reg.sel_hit;
        hq_next.sel_rgb = p5_reg.sel_rgb;
        for (int i = 0; i < 4; i++)
        begin
            ts[i] = hue_setup(tgt[i]);
        end
    end

    rtc_div #(
        .NUM_W (14),
        .DEN_W (8),
        .Q_W   (HUE_Q_W)
    ) u_pix_div (
        .clk (clk),
        .en  (en),
        .num (pix_hs.mag),
        .den (pix_hs.chroma),
        .quo (pix_q)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_tgt_div
        rtc_div #(
            .NUM_W (14),
            .DEN_W (8),
            .Q_W   (HUE_Q_W)
        ) u_tgt_div (
            .clk (clk),
            .en  (en),
            .num (ts[i].mag),
            .den (ts[i].chroma),
            .quo (tgt_q[i])
        );
    end

    // Stage G: nearest target, duotone ramp products
    always_comb
    begin
        carry_t     cq;
        logic [7:0] pix_hue;
        logic       found;
        logic [1:0] best;
        logic [7:0] best_d;
        logic [7:0] s;
        logic [7:0] h;
        cq      = hq_reg[HUE_Q_W-1];
        pix_hue = hue_finish(cq.base, cq.neg, pix_q);
        found   = 1'b0;
        best    = 2'd0;
        best_d  = 8'd0;
        for (int i = 0; i < 4; i++)
        begin
            tgt_hue[i]  = hue_finish(ts[i].base, ts[i].neg, tgt_q[i]);
            tgt_dist[i] = hue_dist(pix_hue, tgt_hue[i]);
            if ((i < HUE_SLOTS) && (3'(i) < nhue) && (ts[i].chroma != 8'd0) &&
                (!found || (tgt_dist[i] < best_d)))
            begin
                found  = 1'b1;
                best   = 2'(i);
                best_d = tgt_dist[i];
            end
        end
        g_next.ch      = cq.ch;
        g_next.nc      = cq.nc;
        g_next.smid    = cq.smid;
        g_next.best    = best;
        g_next.map_on  = (nhue != 3'd0) && (cq.nc >= MIN_HUE_CHROMA) && found;
        g_next.sel_hit = cq.sel_hit;
        g_next.sel_rgb = cq.sel_rgb;
        for (int j = 0; j < 3; j++)
        begin
            s = duotone_reg[8*j +: 8];
            h = duotone_reg[24 + 8*j +: 8];
            g_next.dneg[j] = h < s;
            g_next.dp[j]   = {8'd0, (h < s) ? (s - h) : (h - s)} * {8'd0, cq.smid};
        end
    end

    // Stage H: pull products, duotone ramp
    always_comb
    begin
        hue_setup_t bs;
        logic [8:0] k;
        logic [7:0] dq;
        logic [7:0] s;
        bs = ts[g_reg.best];
        k  = (hue_pull_reg > 9'd256) ? 9'd256 : hue_pull_reg;
        h_next.ch      = g_reg.ch;
        h_next.nc      = g_reg.nc;
        h_next.smid    = g_reg.smid;
        h_next.tch     = tgt[g_reg.best];
        h_next.tc      = bs.chroma;
        h_next.tmid    = bs.mid;
        h_next.mp      = ($signed({1'b0, bs.mid}) - $signed({1'b0, g_reg.smid})) *
                         $signed({1'b0, k});
        h_next.sp      = ($signed({1'b0, bs.chroma}) - $signed({1'b0, g_reg.nc})) *
                         $signed({1'b0, k});
        h_next.map_on  = g_reg.map_on;
        h_next.sel_hit = g_reg.sel_hit;
        h_next.sel_rgb = g_reg.sel_rgb;
        for (int j = 0; j < 3; j++)
        begin
            s  = duotone_reg[8*j +: 8];
            dq = div255(g_reg.dp[j]);
            h_next.ramp[j] = g_reg.dneg[j] ? (s - dq) : (s + dq);
        end
    end

    // Stage I: pulled mid and spread, duotone blend
    always_comb
    begin
        logic signed [10:0] mid11;
        logic signed [10:0] spr11;
        logic [16:0]        bl;
        mid11 = 11'($signed({3'b0, h_reg.smid}) + trunc_q8($signed(h_reg.mp)));
        spr11 = 11'($signed({3'b0, h_reg.nc}) + trunc_q8($signed(h_reg.sp)));
        i_next.mid     = mid11[7:0];
        i_next.spread  = spr11[7:0];
        i_next.tc      = h_reg.tc;
        i_next.map_on  = h_reg.map_on;
        i_next.sel_hit = h_reg.sel_hit;
        i_next.sel_rgb = h_reg.sel_rgb;
        for (int j = 0; j < 3; j++)
        begin
            i_next.diff[j] = 9'($signed({1'b0, h_reg.tch[j]}) - $signed({1'b0, h_reg.tmid}));
            bl = 17'({9'd0, h_reg.ch[j]} * {8'd0, 9'd256 - tint}) +
                 17'({9'd0, h_reg.ramp[j]} * {8'd0, tint});
            i_next.duo[j] = (tint != 9'd0) ? bl[15:8] : h_reg.ch[j];
        end
    end

    // Stage J: spread products into the mapping dividers
    always_comb
    begin
        logic [7:0] dmag;
        mq_next.mid     = i_reg.mid;
        mq_next.map_on  = i_reg.map_on;
        mq_next.duo     = i_reg.duo;
        mq_next.sel_hit = i_reg.sel_hit;
        mq_next.sel_rgb = i_reg.sel_rgb;
        for (int j = 0; j < 3; j++)
        begin
            dmag = i_reg.diff[j][8] ? 8'(-$signed(i_reg.diff[j])) : i_reg.diff[j][7:0];
            mq_next.neg[j] = i_reg.diff[j][8];
            map_num[j]     = {8'd0, dmag} * {8'd0, i_reg.spread};
        end
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_map_div
        rtc_div #(
            .NUM_W (16),
            .DEN_W (8),
            .Q_W   (MAP_Q_W)
        ) u_map_div (
            .clk (clk),
            .en  (en),
            .num (map_num[j]),
            .den (i_reg.tc),
            .quo (map_q[j])
        );
    end

    // Stage K: final select
    always_comb
    begin
        m_t                 mq;
        logic signed [11:0] qs;
        logic signed [11:0] v;
        mq       = mq_reg[MAP_Q_W-1];
        out_next = mq.duo;
        for (int j = 0; j < 3; j++)
        begin
            qs = $signed({3'b0, map_q[j]});
            v  = $signed({4'b0, mq.mid}) + (mq.neg[j] ? -qs : qs);
            if (mq.map_on)
            begin
                out_next[8*j +: 8] = clamp8(v);
            end
        end
        if (mq.sel_hit)
        begin
            out_next = mq.sel_rgb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            p3_reg    <= p3_next;
            p4_reg    <= p4_next;
            p5_reg    <= p5_next;
            hq_reg[0] <= hq_next;
            for (int k = 1; k < HUE_Q_W; k++)
            begin
                hq_reg[k] <= hq_reg[k-1];
            end
            g_reg     <= g_next;
            h_reg     <= h_next;
            i_reg     <= i_next;
            mq_reg[0] <= mq_next;
            for (int k = 1; k < MAP_Q_W; k++)
            begin
                mq_reg[k] <= mq_reg[k-1];
            end
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg        <= '0;
            hv_reg        <= '0;
            tv_reg        <= '0;
            mv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg        <= {pv_reg[3:0], s_tvalid};
            hv_reg        <= {hv_reg[HUE_Q_W-2:0], pv_reg[4]};
            tv_reg        <= {tv_reg[1:0], hv_reg[HUE_Q_W-1]};
            mv_reg        <= {mv_reg[MAP_Q_W-2:0], tv_reg[2]};
            out_valid_reg <= mv_reg[MAP_Q_W-1];
        end
    end

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_map_needs_targets: assert property (@(posedge clk) disable iff (!rst_n)
        (tv_reg[1] && h_reg.map_on) |-> ((nhue != 3'd0) && (h_reg.tc != 8'd0)))
        else $error("hue mapping selected without a usable target");

    a_map_nc_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (tv_reg[1] && h_reg.map_on) |-> (h_reg.nc >= MIN_HUE_CHROMA))
        else $error("hue mapping selected for a low-chroma pixel");

endmodule
